// File: rtl/ofre_pkg.sv
// ofre_pkg: shared types, constants and the feature-count table of the
// optical-flow risk estimator; used by every module under rtl/
package ofre_pkg;

	// number formats
	localparam logic [15:0] Q15_ONE      = 16'd32768;
	localparam logic [9:0]  FEAT_LIMIT   = 10'd20;
	localparam logic [31:0] VAR_LIMIT    = 32'd1000000;
	localparam logic [15:0] COV_LOW_MAX  = 16'd3276;
	localparam logic [15:0] RECIP5       = 16'd52429;   // 2^18 / 5, rounded up
	localparam logic [17:0] FLOW_BIAS    = 18'd512;     // 2.0 in Q8.8

	// turn direction codes
	localparam logic signed [1:0] DIR_NONE  = 2'sb00;
	localparam logic signed [1:0] DIR_RIGHT = 2'sb01;
	localparam logic signed [1:0] DIR_LEFT  = 2'sb11;

	// configuration register indexes
	localparam logic [1:0] CFG_CENTRE_WEIGHT    = 2'd0;
	localparam logic [1:0] CFG_RISK_THRESHOLD   = 2'd1;
	localparam logic [1:0] CFG_SMOOTHING_FACTOR = 2'd2;
	localparam logic [1:0] CFG_URGENCY_SCALE    = 2'd3;

	// operation codes
	localparam logic OP_ESTIMATE = 1'b0;
	localparam logic OP_PRESET   = 1'b1;

	// serial divider geometry
	localparam int DIV_NUM_W = 40;
	localparam int DIV_DEN_W = 18;
	localparam int DIV_QUO_W = 16;
	localparam int DIV_CNT_W = 4;

	// divider operand select
	typedef enum logic {
		DIV_SEL_RISK = 1'b0,
		DIV_SEL_CERT = 1'b1
	} div_sel_t;

	typedef enum logic [9:0] {
		ST_IDLE    = 10'b00_0000_0001,
		ST_MULT    = 10'b00_0000_0010,
		ST_DIVR_GO = 10'b00_0000_0100,
		ST_DIVR    = 10'b00_0000_1000,
		ST_DIVC_GO = 10'b00_0001_0000,
		ST_DIVC    = 10'b00_0010_0000,
		ST_SMOOTH  = 10'b00_0100_0000,
		ST_SUM     = 10'b00_1000_0000,
		ST_SCALE   = 10'b01_0000_0000,
		ST_FIN     = 10'b10_0000_0000
	} state_t;

	typedef struct packed {
		logic     load;
		logic     preset;
		logic     mult;
		logic     div_start;
		div_sel_t div_sel;
		logic     take_risk;
		logic     take_cert;
		logic     smooth;
		logic     sum;
		logic     scale;
		logic     commit;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
	} dp_status_t;

	// floor(32768 * (60 + 7*f) / 200) for f = 0..19
	function automatic logic [15:0] feat_factor(input logic [4:0] f);
		logic [15:0] r;
		unique case (f)
			5'd0:    r = 16'd9830;
			5'd1:    r = 16'd10977;
			5'd2:    r = 16'd12124;
			5'd3:    r = 16'd13271;
			5'd4:    r = 16'd14417;
			5'd5:    r = 16'd15564;
			5'd6:    r = 16'd16711;
			5'd7:    r = 16'd17858;
			5'd8:    r = 16'd19005;
			5'd9:    r = 16'd20152;
			5'd10:   r = 16'd21299;
			5'd11:   r = 16'd22446;
			5'd12:   r = 16'd23592;
			5'd13:   r = 16'd24739;
			5'd14:   r = 16'd25886;
			5'd15:   r = 16'd27033;
			5'd16:   r = 16'd28180;
			5'd17:   r = 16'd29327;
			5'd18:   r = 16'd30474;
			5'd19:   r = 16'd31621;
			default: r = Q15_ONE;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/ofre_div.sv
// ofre_div: serial restoring divider, one quotient bit per cycle
// depends on ofre_pkg for its operand widths
module ofre_div
	import ofre_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] dividend,
	input  logic [DIV_DEN_W-1:0] divisor,
	output logic                 done,
	output logic [DIV_QUO_W-1:0] quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic                 ovf_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_QUO_W-1:0] low_q;
	logic [DIV_QUO_W-1:0] quot_q;

	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   trial_sub;
	logic                 trial_ge;
	logic                 start_ovf;

	// quotient would not fit its width
	assign start_ovf = dividend[DIV_NUM_W-1:DIV_QUO_W] >=
		{{(DIV_NUM_W-DIV_QUO_W-DIV_DEN_W){1'b0}}, divisor};

	assign trial     = {rem_q, low_q[DIV_QUO_W-1]};
	assign trial_ge  = trial >= {1'b0, den_q};
	assign trial_sub = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_QUO_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ovf_q  <= start_ovf;
			den_q  <= divisor;
			rem_q  <= dividend[DIV_QUO_W+DIV_DEN_W-1:DIV_QUO_W];
			low_q  <= dividend[DIV_QUO_W-1:0];
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= trial_ge ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			low_q  <= {low_q[DIV_QUO_W-2:0], 1'b0};
			quot_q <= {quot_q[DIV_QUO_W-2:0], trial_ge};
		end
	end

	assign done     = done_q;
	assign quotient = ovf_q ? '1 : quot_q;

endmodule

// File: rtl/ofre_ctrl.sv
// ofre_ctrl: sequencing state machine and output valid flag
// depends on ofre_pkg for state, command and status types
module ofre_ctrl
	import ofre_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       operation,
	input  logic       flow_invalid,
	output logic       out_valid,
	input  logic       out_ready,
	output dp_cmd_t    cmd,
	input  dp_status_t status
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (operation == OP_PRESET) begin
						cmd.preset = 1'b1;
					end else begin
						cmd.load = 1'b1;
						state_d  = flow_invalid ? ST_FIN : ST_MULT;
					end
				end
			end
			ST_MULT: begin
				cmd.mult = 1'b1;
				state_d  = ST_DIVR_GO;
			end
			ST_DIVR_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_SEL_RISK;
				state_d       = ST_DIVR;
			end
			ST_DIVR: begin
				if (status.div_done) begin
					cmd.take_risk = 1'b1;
					state_d       = ST_DIVC_GO;
				end
			end
			ST_DIVC_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_SEL_CERT;
				state_d       = ST_DIVC;
			end
			ST_DIVC: begin
				if (status.div_done) begin
					cmd.take_cert = 1'b1;
					state_d       = ST_SMOOTH;
				end
			end
			ST_SMOOTH: begin
				cmd.smooth = 1'b1;
				state_d    = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_FIN;
			end
			ST_FIN: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/ofre_dp.sv
// ofre_dp: configuration registers, previous-risk state, arithmetic and
// output registers; depends on ofre_pkg and ofre_div
module ofre_dp
	import ofre_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_status_t         status,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic [15:0]        preset_risk,
	input  logic [15:0]        flow_left,
	input  logic [15:0]        flow_centre,
	input  logic [15:0]        flow_right,
	input  logic               skip_forward,
	input  logic signed [10:0] tracked_features,
	input  logic signed [32:0] variance,
	input  logic signed [16:0] coverage,
	input  logic               flow_invalid,
	input  logic               rotating,
	output logic [15:0]        collision_risk,
	output logic               forward_clear,
	output logic signed [1:0]  turn_direction,
	output logic [15:0]        turn_certainty,
	output logic [15:0]        urgency,
	output logic [15:0]        confidence
);

	// configuration and state
	logic [15:0] cw_q, thr_q, sf_q, us_q;
	logic [15:0] last_risk_q;

	// latched request
	logic [15:0]        l_q, c_q, r_q;
	logic               skip_q, inval_q, rot_q;
	logic signed [10:0] feat_q;
	logic signed [32:0] var_q;
	logic signed [16:0] cov_q;

	// working registers
	logic [16:0] sum_q;
	logic [15:0] diff_q;
	logic signed [1:0] dir_q;
	logic [31:0] cw_prod_q;
	logic [15:0] risk_q, cert_q;
	logic [31:0] p_new_q, p_old_q;
	logic [15:0] growth_q;
	logic [16:0] sg_q;
	logic [32:0] p_urg_q;
	logic [15:0] conf_plain_q;
	logic [33:0] conf_rot_q;

	// output registers
	logic [15:0]       risk_o_q, cert_o_q, urg_o_q, conf_o_q;
	logic              clear_o_q;
	logic signed [1:0] dir_o_q;

	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic [DIV_QUO_W-1:0] div_quo;
	logic                 div_done;
	logic [15:0]          quo_sat;

	logic [15:0] a_eff;
	logic [15:0] a_rem;
	logic [31:0] smooth_sum;
	logic [15:0] c_feat, c_var, c_cov;
	logic        feat_low, var_high, cov_low;
	logic [17:0] conf_x4;
	logic [15:0] urg_sat;

	// shared divider: risk then certainty
	always_comb begin
		unique case (cmd.div_sel)
			DIV_SEL_RISK: begin
				div_num = {cw_prod_q, 8'd0};
				div_den = FLOW_BIAS + {1'b0, sum_q};
			end
			DIV_SEL_CERT: begin
				div_num = {9'd0, diff_q, 15'd0};
				div_den = {1'b0, sum_q};
			end
			default: begin
				div_num = '0;
				div_den = '0;
			end
		endcase
	end

	ofre_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign status.div_done = div_done;
	assign quo_sat = (div_quo > Q15_ONE) ? Q15_ONE : div_quo;

	// smoothing weights, clamped to one
	assign a_eff      = (sf_q > Q15_ONE) ? Q15_ONE : sf_q;
	assign a_rem      = Q15_ONE - a_eff;
	assign smooth_sum = p_new_q + p_old_q;

	// confidence penalties
	assign feat_low = !feat_q[10] && (feat_q[9:0] < FEAT_LIMIT);
	assign var_high = !var_q[32] && (var_q[31:0] > VAR_LIMIT);
	assign cov_low  = !cov_q[16] && (cov_q[15:0] <= COV_LOW_MAX);
	assign c_feat   = feat_low ? feat_factor(feat_q[4:0]) : Q15_ONE;
	assign c_var    = var_high ? {1'b0, c_feat[15:1]} : c_feat;
	assign c_cov    = cov_low ? {1'b0, c_var[15:1]} : c_var;
	assign conf_x4  = {c_cov, 2'b00};

	assign urg_sat = (p_urg_q[32:8] > {9'd0, Q15_ONE}) ? Q15_ONE : p_urg_q[23:8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q        <= 16'd256;
			thr_q       <= 16'd16384;
			sf_q        <= 16'd16384;
			us_q        <= 16'd256;
			last_risk_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CENTRE_WEIGHT:    cw_q  <= cfg_data;
					CFG_RISK_THRESHOLD:   thr_q <= cfg_data;
					CFG_SMOOTHING_FACTOR: sf_q  <= cfg_data;
					CFG_URGENCY_SCALE:    us_q  <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.preset) begin
				last_risk_q <= (preset_risk > Q15_ONE) ? Q15_ONE : preset_risk;
			end else if (cmd.commit && !inval_q) begin
				last_risk_q <= risk_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			l_q     <= flow_left;
			c_q     <= flow_centre;
			r_q     <= flow_right;
			skip_q  <= skip_forward;
			inval_q <= flow_invalid;
			rot_q   <= rotating;
			feat_q  <= tracked_features;
			var_q   <= variance;
			cov_q   <= coverage;
		end
		if (cmd.mult) begin
			cw_prod_q <= c_q * cw_q;
			sum_q     <= {1'b0, l_q} + {1'b0, r_q};
			diff_q    <= (l_q > r_q) ? (l_q - r_q) : (r_q - l_q);
			if (l_q < r_q) begin
				dir_q <= DIR_LEFT;
			end else if (r_q < l_q) begin
				dir_q <= DIR_RIGHT;
			end else begin
				dir_q <= DIR_NONE;
			end
		end
		if (cmd.take_risk) begin
			risk_q <= skip_q ? '0 : quo_sat;
		end
		if (cmd.take_cert) begin
			cert_q <= (sum_q == '0) ? '0 : quo_sat;
		end
		if (cmd.smooth) begin
			p_new_q      <= a_eff * risk_q;
			p_old_q      <= a_rem * last_risk_q;
			growth_q     <= (risk_q > last_risk_q) ? (risk_q - last_risk_q) : '0;
			conf_plain_q <= c_cov;
			conf_rot_q   <= conf_x4 * RECIP5;
		end
		if (cmd.sum) begin
			sg_q <= smooth_sum[31:15] + {1'b0, growth_q};
		end
		if (cmd.scale) begin
			p_urg_q <= sg_q * us_q;
		end
		if (cmd.commit) begin
			if (inval_q) begin
				risk_o_q  <= '0;
				clear_o_q <= 1'b1;
				dir_o_q   <= DIR_NONE;
				cert_o_q  <= '0;
				urg_o_q   <= '0;
				conf_o_q  <= '0;
			end else begin
				risk_o_q  <= risk_q;
				clear_o_q <= risk_q < thr_q;
				dir_o_q   <= dir_q;
				cert_o_q  <= cert_q;
				urg_o_q   <= urg_sat;
				conf_o_q  <= rot_q ? conf_rot_q[33:18] : conf_plain_q;
			end
		end
	end

	assign collision_risk = risk_o_q;
	assign forward_clear  = clear_o_q;
	assign turn_direction = dir_o_q;
	assign turn_certainty = cert_o_q;
	assign urgency        = urg_o_q;
	assign confidence     = conf_o_q;

endmodule

// File: rtl/optical_flow_risk_estimator_unit.sv
// optical_flow_risk_estimator_unit: top level of the optical-flow risk estimator
// depends on ofre_pkg, ofre_ctrl, ofre_dp (and ofre_div inside the datapath)
// a frame request runs the multiply, two passes of the 16-step serial divider (risk, then
// certainty), smoothing, sum and scale; a failed-flow request goes straight to its result;
// a preset request gives no result; a new request is taken only when the last is done
// reset: arst_n clears sequencer, output valid, previous risk; sets config defaults
module optical_flow_risk_estimator_unit
	import ofre_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// request channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic [15:0]        preset_risk,
	input  logic [15:0]        flow_left,
	input  logic [15:0]        flow_centre,
	input  logic [15:0]        flow_right,
	input  logic               skip_forward,
	input  logic signed [10:0] tracked_features,
	input  logic signed [32:0] variance,
	input  logic signed [16:0] coverage,
	input  logic               flow_invalid,
	input  logic               rotating,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        collision_risk,
	output logic               forward_clear,
	output logic signed [1:0]  turn_direction,
	output logic [15:0]        turn_certainty,
	output logic [15:0]        urgency,
	output logic [15:0]        confidence
);

	// command and status between the sequencer and the datapath
	dp_cmd_t    cmd;
	dp_status_t status;

	// sequencer: takes a request only when idle, holds the output valid,
	// and waits in its final state until the output register is free
	ofre_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.flow_invalid (flow_invalid),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cmd          (cmd),
		.status       (status)
	);

	// datapath: gain multiply, shared divider for risk and turn certainty,
	// smoothing and urgency multiplies, confidence penalties, output register
	ofre_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.preset_risk      (preset_risk),
		.flow_left        (flow_left),
		.flow_centre      (flow_centre),
		.flow_right       (flow_right),
		.skip_forward     (skip_forward),
		.tracked_features (tracked_features),
		.variance         (variance),
		.coverage         (coverage),
		.flow_invalid     (flow_invalid),
		.rotating         (rotating),
		.collision_risk   (collision_risk),
		.forward_clear    (forward_clear),
		.turn_direction   (turn_direction),
		.turn_certainty   (turn_certainty),
		.urgency          (urgency),
		.confidence       (confidence)
	);

endmodule
